// ----- hdl/byte_deque_buffer_assert.svh -----
// Assertion macros for the byte deque buffer.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BYTE_DEQUE_BUFFER_ASSERT_SVH
`define BYTE_DEQUE_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bdb_pkg.sv -----
// Shared constants, command codes and control structs of the byte deque buffer.
// No dependencies.
`default_nettype none

package bdb_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int CMD_W  = 3;
  localparam int DATA_W = 8;
  localparam int WORD_W = 16;
  localparam int LIM_W  = 5;
  localparam int OCC_W  = 5;
  localparam int CMP_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PUSH_WORD  = 3'd5;

  typedef struct packed {
    logic load;
    logic exec;
    logic write2;
    logic emit;
  } bdb_cmd_t;

  typedef struct packed {
    logic word_go;
    logic out_free;
  } bdb_stat_t;

endpackage

`default_nettype wire

// ----- hdl/bdb_if.sv -----
// Valid/ready channel interfaces for requests and results of the byte deque buffer.
// Depends on bdb_pkg.
`default_nettype none

interface bdb_in_if;
  logic                         valid;
  logic                         ready;
  logic [bdb_pkg::CMD_W-1:0]    command;
  logic [bdb_pkg::DATA_W-1:0]   data_byte;
  logic [bdb_pkg::WORD_W-1:0]   data_word;

  modport source (output valid, output command, output data_byte, output data_word,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input data_word,
                  output ready);
endinterface

interface bdb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         success;
  logic [bdb_pkg::DATA_W-1:0]   out_byte;
  logic [bdb_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output success, output out_byte, output occupancy,
                  input ready);
  modport sink   (input valid, input success, input out_byte, input occupancy,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/bdb_ctrl.sv -----
// Controller state machine of the byte deque buffer: sequences load, execute,
// second write and result. Depends on bdb_pkg.
`default_nettype none

module bdb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output bdb_pkg::bdb_cmd_t       cmd,
  input  wire bdb_pkg::bdb_stat_t stat
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_WRITE2 = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.word_go ? ST_WRITE2 : ST_EMIT;
      end
      ST_WRITE2: begin
        cmd.write2 = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bdb_datapath.sv -----
// Datapath of the byte deque buffer: byte store, ring pointers, limit register
// and result register. Depends on bdb_pkg.
`default_nettype none

module bdb_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bdb_pkg::bdb_cmd_t            cmd,
  output bdb_pkg::bdb_stat_t                stat,
  input  wire logic                         cfg_we,
  input  wire logic [bdb_pkg::LIM_W-1:0]    cfg_wdata,
  input  wire logic [bdb_pkg::CMD_W-1:0]    in_command,
  input  wire logic [bdb_pkg::DATA_W-1:0]   in_data_byte,
  input  wire logic [bdb_pkg::WORD_W-1:0]   in_data_word,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_success,
  output logic [bdb_pkg::DATA_W-1:0]        out_byte,
  output logic [bdb_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int IDX_W  = bdb_pkg::IDX_W;
  localparam int CNT_W  = bdb_pkg::CNT_W;
  localparam int SUM_W  = bdb_pkg::SUM_W;
  localparam int CMP_W  = bdb_pkg::CMP_W;
  localparam int DATA_W = bdb_pkg::DATA_W;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(bdb_pkg::DEPTH)) begin
      sum = sum - SUM_W'(bdb_pkg::DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  logic [DATA_W-1:0]              store_r [bdb_pkg::DEPTH];
  logic [DATA_W-1:0]              rd_data_r;
  logic [bdb_pkg::CMD_W-1:0]      cmd_r;
  logic [DATA_W-1:0]              byte_r;
  logic [bdb_pkg::WORD_W-1:0]     word_r;
  logic [bdb_pkg::LIM_W-1:0]      limit_r;
  logic [IDX_W-1:0]               front_r, front_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           ok_r, ok_nxt;
  logic                           pop_r, pop_nxt;
  logic                           out_valid_r;
  logic                           out_success_r;
  logic [DATA_W-1:0]              out_byte_r;
  logic [bdb_pkg::OCC_W-1:0]      out_occ_r;

  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic [DATA_W-1:0]              wr_data;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;

  logic [IDX_W-1:0]               back_idx;
  logic [IDX_W-1:0]               last_idx;
  logic [IDX_W-1:0]               prev_front;
  logic [IDX_W-1:0]               next_front;
  logic [CMP_W-1:0]               lim_cmp;
  logic [CMP_W-1:0]               cnt_cmp;
  logic                           room1;
  logic                           room2;
  logic                           not_empty;

  assign back_idx   = ring_add(front_r, count_r);
  assign last_idx   = ring_add(front_r, count_r - CNT_W'(1));
  assign next_front = ring_add(front_r, CNT_W'(1));
  assign prev_front = (front_r == '0) ? IDX_W'(bdb_pkg::DEPTH - 1) : front_r - IDX_W'(1);

  assign lim_cmp   = (CMP_W'(limit_r) > CMP_W'(bdb_pkg::DEPTH)) ?
                     CMP_W'(bdb_pkg::DEPTH) : CMP_W'(limit_r);
  assign cnt_cmp   = CMP_W'(count_r);
  assign room1     = lim_cmp > cnt_cmp;
  assign room2     = room1 && ((lim_cmp - cnt_cmp) >= CMP_W'(2));
  assign not_empty = count_r != '0;

  assign stat.word_go  = (cmd_r == bdb_pkg::CMD_PUSH_WORD) && room2;
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    pop_nxt   = pop_r;
    wr_en     = 1'b0;
    wr_addr   = back_idx;
    wr_data   = byte_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    if (cmd.exec) begin
      ok_nxt  = 1'b0;
      pop_nxt = 1'b0;
      case (cmd_r)
        bdb_pkg::CMD_FLUSH: begin
          front_nxt = '0;
          count_nxt = '0;
          ok_nxt    = 1'b1;
        end
        bdb_pkg::CMD_PUSH_BACK: begin
          if (room1) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        bdb_pkg::CMD_POP_BACK: begin
          if (not_empty) begin
            rd_en     = 1'b1;
            rd_addr   = last_idx;
            count_nxt = count_r - CNT_W'(1);
            ok_nxt    = 1'b1;
            pop_nxt   = 1'b1;
          end
        end
        bdb_pkg::CMD_PUSH_FRONT: begin
          if (room1) begin
            wr_en     = 1'b1;
            wr_addr   = prev_front;
            front_nxt = prev_front;
            count_nxt = count_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end
        bdb_pkg::CMD_POP_FRONT: begin
          if (not_empty) begin
            rd_en     = 1'b1;
            front_nxt = next_front;
            count_nxt = count_r - CNT_W'(1);
            ok_nxt    = 1'b1;
            pop_nxt   = 1'b1;
          end
        end
        bdb_pkg::CMD_PUSH_WORD: begin
          if (room2) begin
            wr_en     = 1'b1;
            wr_data   = word_r[DATA_W-1:0];
            count_nxt = count_r + CNT_W'(2);
            ok_nxt    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.write2) begin
      // The count already includes both bytes, so the high byte goes to the last slot.
      wr_en   = 1'b1;
      wr_addr = last_idx;
      wr_data = word_r[bdb_pkg::WORD_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      byte_r <= in_data_byte;
      word_r <= in_data_word;
    end
    ok_r  <= ok_nxt;
    pop_r <= pop_nxt;
    if (cmd.emit) begin
      out_success_r <= ok_r;
      out_byte_r    <= pop_r ? rd_data_r : '0;
      out_occ_r     <= bdb_pkg::OCC_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      limit_r     <= bdb_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_success   = out_success_r;
  assign out_byte      = out_byte_r;
  assign out_occupancy = out_occ_r;

endmodule

`default_nettype wire

// ----- hdl/byte_deque_buffer.sv -----
// Top level of the byte deque buffer: controller, datapath and assertions.
// Depends on bdb_pkg, bdb_if, bdb_ctrl, bdb_datapath and byte_deque_buffer_assert.svh.
//
// Channel   Direction  Handshake       Payload
// in_chan   in         valid/ready     command, data_byte, data_word
// out_chan  out        valid/ready     success, out_byte, occupancy
// cfg       in         cfg_we          cfg_wdata (capacity limit)
//
// A request steps the controller through accept, execute and result; a word push that fits
// adds a second write state, set by the single write port and registered read port of the
// byte store. Its result is loaded in the result state once the output register is free.
// The next request is accepted while a finished result still waits in the output register.
// Reset is synchronous and clears the queue and sets the limit to 16; no clearing pass.
// A stalled output holds the controller in its result state until the register frees.
`default_nettype none
`include "byte_deque_buffer_assert.svh"

module byte_deque_buffer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bdb_in_if.sink                          in_chan,
  bdb_out_if.source                       out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [bdb_pkg::LIM_W-1:0]  cfg_wdata
);

  bdb_pkg::bdb_cmd_t  cmd;
  bdb_pkg::bdb_stat_t stat;

  bdb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bdb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_command    (in_chan.command),
    .in_data_byte  (in_chan.data_byte),
    .in_data_word  (in_chan.data_word),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_success   (out_chan.success),
    .out_byte      (out_chan.out_byte),
    .out_occupancy (out_chan.occupancy)
  );

  `BDB_ASSERT_SAME(a_occ_bound, out_chan.valid,
                   out_chan.occupancy <= bdb_pkg::OCC_W'(bdb_pkg::DEPTH),
                   "occupancy exceeds depth")
  `BDB_ASSERT_SAME(a_fail_zero, out_chan.valid && !out_chan.success,
                   out_chan.out_byte == '0, "failed request returned a byte")
  `BDB_ASSERT_NEXT(a_one_at_a_time, in_chan.valid && in_chan.ready,
                   !in_chan.ready, "request accepted while another is in work")
  `BDB_ASSERT_SAME(a_emit_free, cmd.emit, stat.out_free,
                   "result loaded over a waiting result")

endmodule

`default_nettype wire
